// ----- src/nnwr_pkg.sv -----
// Shared constants, codes and types of the nearest-neighbour window reservoir.
package nnwr_pkg;

  localparam int unsigned DepthDefault = 256;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned PointW       = 32;
  localparam int unsigned DistW        = 34;
  localparam int unsigned StampW       = 32;
  localparam int unsigned CfgW         = 9;
  localparam int unsigned OutcomeW     = 3;
  localparam int unsigned SlotOutW     = 8;

  localparam logic [OutcomeW-1:0] OUT_FILL   = 3'd0;
  localparam logic [OutcomeW-1:0] OUT_FORMED = 3'd1;
  localparam logic [OutcomeW-1:0] OUT_ADDED  = 3'd2;
  localparam logic [OutcomeW-1:0] OUT_EVICT  = 3'd3;
  localparam logic [OutcomeW-1:0] OUT_ABSORB = 3'd4;

  localparam logic CFG_MIN_FILL = 1'b0;
  localparam logic CFG_MAX_FILL = 1'b1;

  localparam logic [CfgW-1:0] MinFillReset = 9'd150;
  localparam logic [CfgW-1:0] MaxFillReset = 9'd200;

  typedef enum logic [1:0] {
    SCAN_DIST,
    SCAN_AGE,
    SCAN_RANGE
  } scan_mode_e;

  typedef struct packed {
    logic       start;
    scan_mode_e mode;
    logic       skip_en;
  } scan_ctrl_t;

endpackage

// ----- src/nnwr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nnwr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/nnwr_scan.sv -----
// Pipelined scan unit: walks every slot, forms a key and tracks its minimum and maximum.
module nnwr_scan import nnwr_pkg::*; #(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scan_ctrl_t               ctrl_i,
  input  logic [$clog2(Depth)-1:0] skip_i,
  input  logic [PointW-1:0]        ref_pt_i,
  input  logic [StampW-1:0]        stamp_cnt_i,
  input  logic [Depth-1:0]         valid_i,
  output logic [$clog2(Depth)-1:0] addr_o,
  input  logic [PointW-1:0]        pt_rdata_i,
  input  logic [StampW-1:0]        stamp_rdata_i,
  input  logic [DistW-1:0]         dist_rdata_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic [DistW-1:0]         lo_o,
  output logic [$clog2(Depth)-1:0] lo_idx_o,
  output logic [DistW-1:0]         hi_o,
  output logic [$clog2(Depth)-1:0] hi_idx_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned IW = AW + 2;

  logic              run_q, done_q, skip_en_q, found_q;
  scan_mode_e        mode_q;
  logic [IW-1:0]     idx_q;
  logic              tag0;
  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [AW-1:0]     s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [CoordW:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [DistW-1:0] sqx_d, sqy_d;
  logic [DistW-1:0]  sqx_q, sqy_q;
  logic [StampW-1:0] age_d;
  logic [DistW-1:0]  pass2_d, pass2_q, pass3_q, key;
  logic [DistW-1:0]  lo_q, hi_q;
  logic [AW-1:0]     lo_idx_q, hi_idx_q;

  assign addr_o = idx_q[AW-1:0];
  assign tag0   = run_q && (idx_q < IW'(Depth)) && valid_i[addr_o]
                  && !(skip_en_q && (addr_o == skip_i));

  // stage one: differences, or the pass-through key
  assign dx_d = $signed({ref_pt_i[15], ref_pt_i[15:0]})
              - $signed({pt_rdata_i[15], pt_rdata_i[15:0]});
  assign dy_d = $signed({ref_pt_i[31], ref_pt_i[31:16]})
              - $signed({pt_rdata_i[31], pt_rdata_i[31:16]});
  assign age_d   = stamp_cnt_i - stamp_rdata_i;
  assign pass2_d = (mode_q == SCAN_AGE) ? {2'b00, age_d} : dist_rdata_i;

  // stage two: squares
  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;

  // stage three: key and running extremes
  assign key = (mode_q == SCAN_DIST) ? (sqx_q + sqy_q) : pass3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      done_q    <= 1'b0;
      skip_en_q <= 1'b0;
      found_q   <= 1'b0;
      mode_q    <= SCAN_DIST;
      idx_q     <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      s1_v_q <= tag0;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (ctrl_i.start) begin
        run_q     <= 1'b1;
        idx_q     <= '0;
        mode_q    <= ctrl_i.mode;
        skip_en_q <= ctrl_i.skip_en;
        found_q   <= 1'b0;
      end else if (run_q) begin
        idx_q <= idx_q + IW'(1);
        if (idx_q == IW'(Depth + 2)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        if (s3_v_q) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= addr_o;
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    pass2_q  <= pass2_d;
    sqx_q    <= unsigned'(sqx_d);
    sqy_q    <= unsigned'(sqy_d);
    pass3_q  <= pass2_q;
    if (run_q && s3_v_q) begin
      if (!found_q || key < lo_q) begin
        lo_q     <= key;
        lo_idx_q <= s3_idx_q;
      end
      if (!found_q || key > hi_q) begin
        hi_q     <= key;
        hi_idx_q <= s3_idx_q;
      end
    end
  end

  assign done_o   = done_q;
  assign found_o  = found_q;
  assign lo_o     = lo_q;
  assign lo_idx_o = lo_idx_q;
  assign hi_o     = hi_q;
  assign hi_idx_o = hi_idx_q;

endmodule

// ----- src/nearest_neighbor_window_reservoir.sv -----
// Top level of the nearest-neighbour window reservoir: sequencer, state and stores.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_stall_o, coord_x/y_i  | in
//  out     | out_valid_o, out_stall_i, outcome_o, | out
//          | slot_o, evicted_slot_o, nearest_..., |
//          | range_low_o, range_high_o            |
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i      | in
//
// One word at a time; in_stall_o stays high from acceptance until the result is taken.
// Every slot walk runs through the shared scan unit.
// Filling word: a free-slot search, plus, for the word that forms the range, one walk per
// stored point and one more walk for the range itself.
// Later words: 1 to 4 walks.
// Reset clears the state, fill count, stamp counter, range, settings and valid bits; the stores need no clearing pass.
module nearest_neighbor_window_reservoir import nnwr_pkg::*; #(
  parameter int unsigned WindowDepth = DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CoordW-1:0]    coord_x_i,
  input  logic [CoordW-1:0]    coord_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OutcomeW-1:0]  outcome_o,
  output logic [SlotOutW-1:0]  slot_o,
  output logic [SlotOutW-1:0]  evicted_slot_o,
  output logic [DistW-1:0]     nearest_sq_dist_o,
  output logic [DistW-1:0]     range_low_o,
  output logic [DistW-1:0]     range_high_o
);

  localparam int unsigned AW = $clog2(WindowDepth);
  localparam int unsigned CW = $clog2(WindowDepth + 1);
  localparam int unsigned LW = (CW > CfgW) ? CW : CfgW;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FREE      = 4'd1;
  localparam logic [3:0] S_FORM_RD   = 4'd2;
  localparam logic [3:0] S_FORM_LAT  = 4'd3;
  localparam logic [3:0] S_FORM_SCAN = 4'd4;
  localparam logic [3:0] S_NEAR      = 4'd5;
  localparam logic [3:0] S_EVICT     = 4'd6;
  localparam logic [3:0] S_NEAR2     = 4'd7;
  localparam logic [3:0] S_RANGE     = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  function automatic logic [CW-1:0] clamp_fill(input logic [CfgW-1:0] v);
    logic [LW-1:0] ve;
    ve = LW'(v);
    if (ve < LW'(2)) begin
      return CW'(2);
    end else if (ve > LW'(WindowDepth)) begin
      return CW'(WindowDepth);
    end
    return CW'(ve);
  endfunction

  logic [3:0]          state_q, state_d;
  logic [CfgW-1:0]     min_fill_q, max_fill_q;
  logic [CW-1:0]       count_q, count_d, mn_q, mn_d, mx_q, mx_d, mn_cl, mx_cl;
  logic [StampW-1:0]   sc_q, sc_d;
  logic [DistW-1:0]    rlo_q, rlo_d, rhi_q, rhi_d, ndist_q, ndist_d, scan_best;
  logic [WindowDepth-1:0] valid_q, valid_d;
  logic [PointW-1:0]   in_pt_q, in_pt_d, pt_ref_q, pt_ref_d;
  logic [AW-1:0]       fc_q, fc_d, slot_q, slot_d, evict_q, evict_d;
  logic [AW:0]         fi_q, fi_d;
  logic                adding_q, adding_d;
  logic [OutcomeW-1:0] outcome_q, outcome_d;

  scan_ctrl_t          scan_ctrl;
  logic [AW-1:0]       scan_addr, lo_idx, hi_idx;
  logic                scan_done, scan_found;
  logic [DistW-1:0]    scan_lo, scan_hi;

  logic                pt_we, st_we, nn_we;
  logic [AW-1:0]       pt_waddr, st_waddr, nn_waddr, pt_raddr;
  logic [DistW-1:0]    nn_wdata;
  logic [PointW-1:0]   pt_rdata;
  logic [StampW-1:0]   st_rdata;
  logic [DistW-1:0]    nn_rdata;

  assign mn_cl     = clamp_fill(min_fill_q);
  assign mx_cl     = clamp_fill(max_fill_q);
  assign scan_best = scan_found ? scan_lo : '0;
  assign pt_raddr  = (state_q == S_FORM_RD) ? fi_q[AW-1:0] : scan_addr;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    mn_d      = mn_q;
    mx_d      = mx_q;
    sc_d      = sc_q;
    rlo_d     = rlo_q;
    rhi_d     = rhi_q;
    ndist_d   = ndist_q;
    valid_d   = valid_q;
    in_pt_d   = in_pt_q;
    pt_ref_d  = pt_ref_q;
    fc_d      = fc_q;
    fi_d      = fi_q;
    slot_d    = slot_q;
    evict_d   = evict_q;
    adding_d  = adding_q;
    outcome_d = outcome_q;
    scan_ctrl = '{start: 1'b0, mode: SCAN_DIST, skip_en: 1'b0};
    pt_we     = 1'b0;
    st_we     = 1'b0;
    nn_we     = 1'b0;
    pt_waddr  = slot_q;
    st_waddr  = slot_q;
    nn_waddr  = slot_q;
    nn_wdata  = scan_best;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_pt_d  = {coord_y_i, coord_x_i};
          pt_ref_d = {coord_y_i, coord_x_i};
          mn_d     = mn_cl;
          mx_d     = (mx_cl < mn_cl) ? mn_cl : mx_cl;
          evict_d  = '0;
          ndist_d  = '0;
          fc_d     = '0;
          if (count_q < mn_cl) begin
            adding_d = 1'b0;
            state_d  = S_FREE;
          end else begin
            scan_ctrl.start = 1'b1;
            state_d         = S_NEAR;
          end
        end
      end
      S_FREE: begin
        if (!valid_q[fc_q]) begin
          slot_d  = fc_q;
          count_d = count_q + CW'(1);
          if (!adding_q) begin
            pt_we           = 1'b1;
            pt_waddr        = fc_q;
            st_we           = 1'b1;
            st_waddr        = fc_q;
            valid_d[fc_q]   = 1'b1;
            sc_d            = sc_q + StampW'(1);
            if (count_q + CW'(1) == mn_q) begin
              outcome_d = OUT_FORMED;
              fi_d      = '0;
              state_d   = S_FORM_RD;
            end else begin
              outcome_d = OUT_FILL;
              state_d   = S_OUT;
            end
          end else begin
            outcome_d       = OUT_ADDED;
            scan_ctrl.start = 1'b1;
            state_d         = S_NEAR2;
          end
        end else begin
          fc_d = fc_q + AW'(1);
        end
      end
      S_FORM_RD: begin
        if (fi_q == (AW+1)'(WindowDepth)) begin
          scan_ctrl = '{start: 1'b1, mode: SCAN_RANGE, skip_en: 1'b0};
          state_d   = S_RANGE;
        end else if (valid_q[fi_q[AW-1:0]]) begin
          state_d = S_FORM_LAT;
        end else begin
          fi_d = fi_q + (AW+1)'(1);
        end
      end
      S_FORM_LAT: begin
        pt_ref_d  = pt_rdata;
        scan_ctrl = '{start: 1'b1, mode: SCAN_DIST, skip_en: 1'b1};
        state_d   = S_FORM_SCAN;
      end
      S_FORM_SCAN: begin
        if (scan_done) begin
          nn_we    = 1'b1;
          nn_waddr = fi_q[AW-1:0];
          fi_d     = fi_q + (AW+1)'(1);
          state_d  = S_FORM_RD;
        end
      end
      S_NEAR: begin
        if (scan_done) begin
          ndist_d = scan_best;
          if (scan_best < rlo_q || scan_best > rhi_q) begin
            if (count_q >= mx_q) begin
              scan_ctrl = '{start: 1'b1, mode: SCAN_AGE, skip_en: 1'b0};
              state_d   = S_EVICT;
            end else begin
              adding_d = 1'b1;
              state_d  = S_FREE;
            end
          end else begin
            // absorb: refresh the representative's stamp
            st_we     = 1'b1;
            st_waddr  = lo_idx;
            sc_d      = sc_q + StampW'(1);
            slot_d    = lo_idx;
            outcome_d = OUT_ABSORB;
            state_d   = S_OUT;
          end
        end
      end
      S_EVICT: begin
        if (scan_done) begin
          valid_d[hi_idx] = 1'b0;
          slot_d          = hi_idx;
          evict_d         = hi_idx;
          outcome_d       = OUT_EVICT;
          scan_ctrl.start = 1'b1;
          state_d         = S_NEAR2;
        end
      end
      S_NEAR2: begin
        if (scan_done) begin
          pt_we           = 1'b1;
          st_we           = 1'b1;
          nn_we           = 1'b1;
          valid_d[slot_q] = 1'b1;
          sc_d            = sc_q + StampW'(1);
          scan_ctrl       = '{start: 1'b1, mode: SCAN_RANGE, skip_en: 1'b0};
          state_d         = S_RANGE;
        end
      end
      S_RANGE: begin
        if (scan_done) begin
          rlo_d   = scan_found ? scan_lo : '0;
          rhi_d   = scan_found ? scan_hi : '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      min_fill_q <= MinFillReset;
      max_fill_q <= MaxFillReset;
      count_q    <= '0;
      sc_q       <= '0;
      rlo_q      <= '0;
      rhi_q      <= '0;
      valid_q    <= '0;
      adding_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sc_q     <= sc_d;
      rlo_q    <= rlo_d;
      rhi_q    <= rhi_d;
      valid_q  <= valid_d;
      adding_q <= adding_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_FILL: min_fill_q <= cfg_data_i;
          CFG_MAX_FILL: max_fill_q <= cfg_data_i;
          default:      min_fill_q <= min_fill_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mn_q      <= mn_d;
    mx_q      <= mx_d;
    ndist_q   <= ndist_d;
    in_pt_q   <= in_pt_d;
    pt_ref_q  <= pt_ref_d;
    fc_q      <= fc_d;
    fi_q      <= fi_d;
    slot_q    <= slot_d;
    evict_q   <= evict_d;
    outcome_q <= outcome_d;
  end

  nnwr_scan #(.Depth(WindowDepth)) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .skip_i        (fi_q[AW-1:0]),
    .ref_pt_i      (pt_ref_q),
    .stamp_cnt_i   (sc_q),
    .valid_i       (valid_q),
    .addr_o        (scan_addr),
    .pt_rdata_i    (pt_rdata),
    .stamp_rdata_i (st_rdata),
    .dist_rdata_i  (nn_rdata),
    .done_o        (scan_done),
    .found_o       (scan_found),
    .lo_o          (scan_lo),
    .lo_idx_o      (lo_idx),
    .hi_o          (scan_hi),
    .hi_idx_o      (hi_idx)
  );

  nnwr_ram #(.Width(PointW), .Depth(WindowDepth)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (in_pt_q),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  nnwr_ram #(.Width(StampW), .Depth(WindowDepth)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (sc_q),
    .raddr_i (scan_addr),
    .rdata_o (st_rdata)
  );

  nnwr_ram #(.Width(DistW), .Depth(WindowDepth)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (nn_we),
    .waddr_i (nn_waddr),
    .wdata_i (nn_wdata),
    .raddr_i (scan_addr),
    .rdata_o (nn_rdata)
  );

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_OUT);
  assign outcome_o         = outcome_q;
  assign slot_o            = SlotOutW'(slot_q);
  assign evicted_slot_o    = SlotOutW'(evict_q);
  assign nearest_sq_dist_o = ndist_q;
  assign range_low_o       = rlo_q;
  assign range_high_o      = rhi_q;

endmodule

// ----- src/nnwr_checker.sv -----
// Port-level checks of the nearest-neighbour window reservoir, bound to the top level.
module nnwr_checker import nnwr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [OutcomeW-1:0] outcome_o,
  input logic [SlotOutW-1:0] evicted_slot_o,
  input logic [DistW-1:0]    nearest_sq_dist_o,
  input logic [DistW-1:0]    range_low_o,
  input logic [DistW-1:0]    range_high_o
);

  // hold the input side while a result word waits
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outcome_o == OUT_FILL || outcome_o == OUT_FORMED ||
                     outcome_o == OUT_ADDED || outcome_o == OUT_EVICT ||
                     outcome_o == OUT_ABSORB))
    else $error("bad outcome code");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o != OUT_EVICT) |-> (evicted_slot_o == '0))
    else $error("evicted slot set without eviction");

  a_fill_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (outcome_o == OUT_FILL || outcome_o == OUT_FORMED))
      |-> (nearest_sq_dist_o == '0))
    else $error("distance reported while filling");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |-> (range_low_o <= range_high_o))
    else $error("range inverted");

endmodule

bind nearest_neighbor_window_reservoir nnwr_checker u_nnwr_checker (.*);

// ----- tb/nnwr_checker.sv -----
// Watches the reservoir's channels, predicts each result word and compares it.
module nnwr_monitor import nnwr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CoordW-1:0]   coord_x_i,
  input  logic [CoordW-1:0]   coord_y_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [OutcomeW-1:0] outcome_i,
  input  logic [SlotOutW-1:0] slot_i,
  input  logic [SlotOutW-1:0] evicted_slot_i,
  input  logic [DistW-1:0]    nearest_sq_dist_i,
  input  logic [DistW-1:0]    range_low_i,
  input  logic [DistW-1:0]    range_high_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = DepthDefault;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [SlotOutW-1:0] slot;
    logic [SlotOutW-1:0] evicted;
    logic [DistW-1:0]    near;
    logic [DistW-1:0]    lo;
    logic [DistW-1:0]    hi;
  } window_result_t;

  logic [PointW-1:0] win_point [Depth];
  logic [DistW-1:0]  win_nn    [Depth];
  logic [StampW-1:0] win_stamp [Depth];
  bit                win_used  [Depth];
  int unsigned       fill_count;
  logic [StampW-1:0] tick;
  logic [DistW-1:0]  span_lo, span_hi;
  logic [CfgW-1:0]   min_fill_reg, max_fill_reg;
  window_result_t    awaited_q[$];

  initial begin
    foreach (win_used[i]) win_used[i] = 1'b0;
    fill_count = 0;
    tick = '0;
    span_lo = '0;
    span_hi = '0;
    min_fill_reg = MinFillReset;
    max_fill_reg = MaxFillReset;
    errors_o = 0;
    pending_o = 0;
    checked_o = 0;
  end

  function automatic logic [DistW-1:0] sq_gap(logic [PointW-1:0] a, logic [PointW-1:0] b);
    longint dx, dy;
    dx = longint'($signed(a[15:0])) - longint'($signed(b[15:0]));
    dy = longint'($signed(a[31:16])) - longint'($signed(b[31:16]));
    return DistW'(dx * dx + dy * dy);
  endfunction

  function automatic int unsigned clamp_fill(logic [CfgW-1:0] v);
    if (v < 2) return 2;
    if (v > Depth) return Depth;
    return 32'(v);
  endfunction

  // Nearest used slot, skipping one; ties keep the lowest slot.
  function automatic bit closest_slot(input logic [PointW-1:0] p, input int skip,
                                      output int s, output logic [DistW-1:0] d);
    bit found;
    logic [DistW-1:0] g;
    found = 1'b0;
    s = 0;
    d = '0;
    for (int i = 0; i < Depth; i++) begin
      if (win_used[i] && i != skip) begin
        g = sq_gap(p, win_point[i]);
        if (!found || g < d) begin
          d = g;
          s = i;
          found = 1'b1;
        end
      end
    end
    return found;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < Depth; i++) if (!win_used[i]) return i;
    return 0;
  endfunction

  function automatic void refresh_span();
    bit any;
    any = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      if (win_used[i]) begin
        if (!any || win_nn[i] < span_lo) span_lo = win_nn[i];
        if (!any || win_nn[i] > span_hi) span_hi = win_nn[i];
        any = 1'b1;
      end
    end
    if (!any) begin
      span_lo = '0;
      span_hi = '0;
    end
  endfunction

  function automatic void place(int s, logic [PointW-1:0] p);
    win_point[s] = p;
    win_used[s] = 1'b1;
    win_stamp[s] = tick;
    tick++;
  endfunction

  function automatic window_result_t place_or_absorb(logic [PointW-1:0] p);
    window_result_t r;
    int unsigned mn, mx;
    int s, ns, ts, victim;
    logic [DistW-1:0] nd, d;
    logic [StampW-1:0] age, oldest;
    bit seen;
    r = '0;
    mn = clamp_fill(min_fill_reg);
    mx = clamp_fill(max_fill_reg);
    if (mx < mn) mx = mn;
    if (fill_count < mn) begin
      s = first_free();
      place(s, p);
      fill_count++;
      r.outcome = OUT_FILL;
      r.slot = s[7:0];
      if (fill_count == mn) begin
        for (int i = 0; i < Depth; i++) begin
          if (win_used[i]) begin
            if (!closest_slot(win_point[i], i, ts, d)) d = '0;
            win_nn[i] = d;
          end
        end
        refresh_span();
        r.outcome = OUT_FORMED;
      end
    end else begin
      if (!closest_slot(p, Depth, ns, nd)) nd = '0;
      r.near = nd;
      if (nd < span_lo || nd > span_hi) begin
        if (fill_count >= mx) begin
          seen = 1'b0;
          victim = 0;
          oldest = '0;
          for (int i = 0; i < Depth; i++) begin
            if (win_used[i]) begin
              age = tick - win_stamp[i];
              if (!seen || age > oldest) begin
                oldest = age;
                victim = i;
                seen = 1'b1;
              end
            end
          end
          win_used[victim] = 1'b0;
          s = victim;
          r.evicted = victim[7:0];
          r.outcome = OUT_EVICT;
        end else begin
          s = first_free();
          fill_count++;
          r.outcome = OUT_ADDED;
        end
        if (!closest_slot(p, Depth, ts, d)) d = '0;
        place(s, p);
        win_nn[s] = d;
        refresh_span();
        r.slot = s[7:0];
      end else begin
        r.slot = ns[7:0];
        win_stamp[ns] = tick;
        tick++;
        r.outcome = OUT_ABSORB;
      end
    end
    r.lo = span_lo;
    r.hi = span_hi;
    return r;
  endfunction

  always @(posedge clk_i) begin
    window_result_t want, got;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = '{outcome_i, slot_i, evicted_slot_i, nearest_sq_dist_i,
                range_low_i, range_high_i};
        if (awaited_q.size() == 0) begin
          if (errors_o < 10) $display("%0t: result word with nothing awaited", $realtime);
          errors_o++;
        end else begin
          want = awaited_q.pop_front();
          checked_o++;
          if (got !== want) begin
            if (errors_o < 10)
              $display("%0t: mismatch exp o=%0d s=%0d e=%0d d=%0d lo=%0d hi=%0d %s",
                       $realtime, want.outcome, want.slot, want.evicted, want.near,
                       want.lo, want.hi, $sformatf("got o=%0d s=%0d e=%0d d=%0d lo=%0d hi=%0d",
                       got.outcome, got.slot, got.evicted, got.near, got.lo, got.hi));
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_q = {awaited_q, place_or_absorb({coord_y_i, coord_x_i})};
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MIN_FILL) min_fill_reg = cfg_data_i;
        else max_fill_reg = cfg_data_i;
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ----- tb/nearest_neighbor_window_reservoir_tb.sv -----
// Stimulus and verdict for the nearest-neighbour window reservoir.
module nearest_neighbor_window_reservoir_tb;
  import nnwr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 10000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = CFG_MIN_FILL;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CoordW-1:0]   coord_x_i = '0;
  logic [CoordW-1:0]   coord_y_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [OutcomeW-1:0] outcome_o;
  logic [SlotOutW-1:0] slot_o, evicted_slot_o;
  logic [DistW-1:0]    nearest_sq_dist_o, range_low_o, range_high_o;
  int                  errors, pending, checked;
  int                  cycles = 0;
  int                  sent = 0;
  bit                  calm = 1'b0;
  int                  hold_left = 0;
  logic [CoordW-1:0]   hub_x [4], hub_y [4];
  int                  spread;
  logic [CfgW-1:0]     min_list [7] = '{9'd1, 9'd6, 9'd6, 9'd20, 9'd10, 9'd256, 9'd2};
  logic [CfgW-1:0]     max_list [7] = '{9'd0, 9'd12, 9'd3, 9'd40, 9'd4, 9'd511, 9'd256};
  int                  count_list [7] = '{60, 150, 120, 200, 120, 300, 200};

  nearest_neighbor_window_reservoir DUT (.*);

  nnwr_monitor u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .coord_x_i, .coord_y_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .outcome_i(outcome_o), .slot_i(slot_o), .evicted_slot_i(evicted_slot_o),
    .nearest_sq_dist_i(nearest_sq_dist_o), .range_low_i(range_low_o),
    .range_high_i(range_high_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 18) - 1;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  task automatic send_word(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk_i);
    in_valid_i = 1'b1;
    coord_x_i = x;
    coord_y_i = y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly clustered points so that absorbs and additions both occur.
  task automatic send_random();
    int pick, h;
    logic [CoordW-1:0] x, y;
    pick = $urandom_range(0, 9);
    h = $urandom_range(0, 3);
    if (pick < 2) begin
      x = CoordW'($urandom);
      y = CoordW'($urandom);
    end else if (pick == 2) begin
      x = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      y = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
    end else begin
      x = hub_x[h] + CoordW'($urandom_range(0, spread)) - CoordW'(spread / 2);
      y = hub_y[h] + CoordW'($urandom_range(0, spread)) - CoordW'(spread / 2);
    end
    send_word(x, y);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: smallest window, far corners, duplicates and equal-distance ties.
    write_reg(CFG_MIN_FILL, 9'd0);
    write_reg(CFG_MAX_FILL, 9'd1);
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h0000, 16'h0000);
    send_word(16'h7FFF, 16'h8000);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h0001, 16'h0000);
    send_word(16'hFFFF, 16'h0000);
    send_word(16'h0000, 16'h0001);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'h0000, 16'h0000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hAAAA, 16'h5555);
    send_word(16'hFFFF, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_MIN_FILL, min_list[ph]);
      write_reg(CFG_MAX_FILL, max_list[ph]);
      spread = (ph % 2 == 0) ? 64 : 4096;
      foreach (hub_x[i]) begin
        hub_x[i] = CoordW'($urandom);
        hub_y[i] = CoordW'($urandom);
      end
      for (int n = 0; n < count_list[ph]; n++) begin
        if (ph == 6 && n == count_list[ph] / 2) calm = 1'b1;
        if (n == 30) drain();
        send_random();
      end
      drain();
    end

    $display("Sent %0d points through 8 window settings, clamped and raw extremes included;",
             sent);
    $display("%0d result words compared, %0d failures.", checked, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/nnwr_pkg.sv
src/nnwr_ram.sv
src/nnwr_scan.sv
src/nearest_neighbor_window_reservoir.sv
src/nnwr_checker.sv
tb/nnwr_checker.sv
tb/nearest_neighbor_window_reservoir_tb.sv
